// ===== design/tbdc_pkg.sv =====
// Package for the two-button debounce block: types, codes and the per-machine step function.
`default_nettype none

package tbdc_pkg;

  // Widths
  localparam int TICK_WIDTH  = 32;
  localparam int DELAY_WIDTH = 32;
  localparam int DIFF_WIDTH  = (TICK_WIDTH > DELAY_WIDTH) ? TICK_WIDTH : DELAY_WIDTH;
  localparam int CFG_IDX_WIDTH = 2;

  // Register reset values
  localparam logic [DELAY_WIDTH-1:0] PRESS_DELAY_RST         = DELAY_WIDTH'(20);
  localparam logic [DELAY_WIDTH-1:0] RELEASE_DELAY_RST       = DELAY_WIDTH'(50);
  localparam logic [DELAY_WIDTH-1:0] CHORD_RELEASE_DELAY_RST = DELAY_WIDTH'(100);

  typedef logic [TICK_WIDTH-1:0]  tick_t;
  typedef logic [DELAY_WIDTH-1:0] delay_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_PRESS_DELAY         = 2'd0,
    REG_RELEASE_DELAY       = 2'd1,
    REG_CHORD_RELEASE_DELAY = 2'd2
  } reg_idx_t;

  // Debounce machine phases
  typedef enum logic [1:0] {
    PH_RELEASED     = 2'd0,
    PH_PRESS_WAIT   = 2'd1,
    PH_PRESSED      = 2'd2,
    PH_RELEASE_WAIT = 2'd3
  } phase_t;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_LEFT_DOWN  = 3'd1,
    EV_LEFT_UP    = 3'd2,
    EV_RIGHT_DOWN = 3'd3,
    EV_RIGHT_UP   = 3'd4,
    EV_BOTH_DOWN  = 3'd5,
    EV_BOTH_UP    = 3'd6
  } evt_t;

  // Request payload
  typedef struct packed {
    logic  left_pressed;
    logic  right_pressed;
    tick_t now_ticks;
  } sample_t;

  // Result payload
  typedef struct packed {
    evt_t event_code;
    logic left_held;
    logic right_held;
    logic both_held;
  } result_t;

  // One machine after a step
  typedef struct packed {
    phase_t phase;
    tick_t  stamp;
    logic   down;
    logic   up;
  } mach_t;

  // One debounce step: absolute tick difference, compare against the delay
  function automatic mach_t mach_step(phase_t ph, tick_t stamp, logic act, tick_t now,
                                      delay_t dly_press, delay_t dly_release);
    mach_t                 r;
    tick_t                 diff;
    logic [DIFF_WIDTH-1:0] diff_x;
    logic [DIFF_WIDTH-1:0] press_x;
    logic [DIFF_WIDTH-1:0] release_x;
    diff      = (now > stamp) ? (now - stamp) : (stamp - now);
    diff_x    = DIFF_WIDTH'(diff);
    press_x   = DIFF_WIDTH'(dly_press);
    release_x = DIFF_WIDTH'(dly_release);
    r.phase   = ph;
    r.stamp   = stamp;
    r.down    = 1'b0;
    r.up      = 1'b0;
    unique case (ph)
      PH_RELEASED: begin
        if (act) begin
          if (dly_press != '0) begin
            r.phase = PH_PRESS_WAIT;
            r.stamp = now;
          end else begin
            r.down  = 1'b1;
            r.phase = PH_PRESSED;
          end
        end
      end
      PH_PRESS_WAIT: begin
        if (!act) begin
          r.phase = PH_RELEASED;
        end else if (diff_x > press_x) begin
          r.down  = 1'b1;
          r.phase = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!act) begin
          if (dly_release != '0) begin
            r.phase = PH_RELEASE_WAIT;
            r.stamp = now;
          end else begin
            r.up    = 1'b1;
            r.phase = PH_RELEASED;
          end
        end
      end
      PH_RELEASE_WAIT: begin
        if (act) begin
          r.phase = PH_PRESSED;
        end else if (diff_x > release_x) begin
          r.up    = 1'b1;
          r.phase = PH_RELEASED;
        end
      end
      default: begin
        r.phase = PH_RELEASED;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_held(phase_t ph);
    return (ph == PH_PRESSED) || (ph == PH_RELEASE_WAIT);
  endfunction

endpackage

`default_nettype wire

// ===== design/two_button_debounce_chord.sv =====
// Top level of the two-button debounce and chord detector.
//
//  channel   direction  handshake              payload
//  sample    in         in_valid / in_ready    sample_t (buttons, tick count)
//  result    out        out_valid / out_ready  result_t (event, held flags)
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// Each request is held in the input register, then its result is computed in
// one pass and lands in the output register; one request per cycle is sustained
// while the output is not stalled. The phase/stamp registers update as a request
// moves into the output register. A stalled output holds both stages; the input
// register is free again as soon as its request moves on. Reset is synchronous
// and restores the released phases, zero stamps and default delays.
`default_nettype none

module two_button_debounce_chord
  import tbdc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire sample_t                  sample,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output result_t                       result,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [DELAY_WIDTH-1:0]   cfg_data
);

  // Configuration
  delay_t press_delay;
  delay_t release_delay;
  delay_t chord_release_delay;

  // Machine state
  phase_t left_phase, left_phase_next;
  phase_t right_phase, right_phase_next;
  phase_t chord_phase, chord_phase_next;
  tick_t  left_stamp, left_stamp_next;
  tick_t  right_stamp, right_stamp_next;
  tick_t  chord_stamp, chord_stamp_next;

  // Pipeline
  logic    in_q_valid;
  sample_t in_q;
  logic    advance;
  result_t result_next;

  // Step results and event selects
  mach_t lres, rres, cres;
  logic  left_fire, right_fire, chord_start, chord_fire;
  mach_t chord_sel;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      press_delay         <= PRESS_DELAY_RST;
      release_delay       <= RELEASE_DELAY_RST;
      chord_release_delay <= CHORD_RELEASE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESS_DELAY:         press_delay         <= cfg_data;
        REG_RELEASE_DELAY:       release_delay       <= cfg_data;
        REG_CHORD_RELEASE_DELAY: chord_release_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= sample;
    end
  end

  // Next state of the three machines
  always_comb begin
    lres = mach_step(left_phase, left_stamp, in_q.left_pressed, in_q.now_ticks,
                     press_delay, release_delay);
    rres = mach_step(right_phase, right_stamp, in_q.right_pressed, in_q.now_ticks,
                     press_delay, release_delay);
    cres = mach_step(chord_phase, chord_stamp, in_q.left_pressed | in_q.right_pressed,
                     in_q.now_ticks, '0, chord_release_delay);

    left_phase_next  = left_phase;
    left_stamp_next  = left_stamp;
    right_phase_next = right_phase;
    right_stamp_next = right_stamp;
    chord_phase_next = chord_phase;
    chord_stamp_next = chord_stamp;
    left_fire   = 1'b0;
    right_fire  = 1'b0;
    chord_start = 1'b0;
    chord_fire  = 1'b0;
    chord_sel   = cres;

    if (chord_phase == PH_RELEASED) begin
      left_phase_next = lres.phase;
      left_stamp_next = lres.stamp;
      left_fire       = lres.down | lres.up;
      // right runs only when left gave no event
      if (!left_fire) begin
        right_phase_next = rres.phase;
        right_stamp_next = rres.stamp;
        right_fire       = rres.down | rres.up;
      end
      // both singles active: chord takes over at once
      if (!left_fire && !right_fire &&
          left_phase_next != PH_RELEASED && right_phase_next != PH_RELEASED) begin
        chord_start      = 1'b1;
        chord_phase_next = PH_PRESSED;
        left_phase_next  = PH_RELEASED;
        right_phase_next = PH_RELEASED;
      end
    end else begin
      chord_phase_next = cres.phase;
      chord_stamp_next = cres.stamp;
      chord_fire       = cres.up;
      if (cres.phase == PH_RELEASED) begin
        left_phase_next  = PH_RELEASED;
        right_phase_next = PH_RELEASED;
      end
    end
  end

  // Result fields
  always_comb begin
    result_next.event_code = EV_NONE;
    if (left_fire) begin
      result_next.event_code = lres.down ? EV_LEFT_DOWN : EV_LEFT_UP;
    end else if (right_fire) begin
      result_next.event_code = rres.down ? EV_RIGHT_DOWN : EV_RIGHT_UP;
    end else if (chord_start) begin
      result_next.event_code = EV_BOTH_DOWN;
    end else if (chord_fire && chord_sel.up) begin
      result_next.event_code = EV_BOTH_UP;
    end
    result_next.left_held  = is_held(left_phase_next);
    result_next.right_held = is_held(right_phase_next);
    result_next.both_held  = is_held(chord_phase_next);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_phase  <= PH_RELEASED;
      right_phase <= PH_RELEASED;
      chord_phase <= PH_RELEASED;
      left_stamp  <= '0;
      right_stamp <= '0;
      chord_stamp <= '0;
    end else if (advance) begin
      left_phase  <= left_phase_next;
      right_phase <= right_phase_next;
      chord_phase <= chord_phase_next;
      left_stamp  <= left_stamp_next;
      right_stamp <= right_stamp_next;
      chord_stamp <= chord_stamp_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Checks
  a_chord_freezes_singles: assert property (@(posedge clk) disable iff (rst)
    (chord_phase != PH_RELEASED) |-> (left_phase == PH_RELEASED && right_phase == PH_RELEASED))
    else $error("single machine active while chord held");

  a_held_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.both_held) |-> (!result.left_held && !result.right_held))
    else $error("single held flag set with chord held");

  a_both_down_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.event_code == EV_BOTH_DOWN) |-> result.both_held)
    else $error("both-down without chord held");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("computed request lost");

endmodule

`default_nettype wire
